[src/i2p_pkg.sv]
// package with types, operator codes and lookup functions of the infix to postfix converter
`timescale 1ns / 1ps

package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    typedef logic [2:0] t_code;

    localparam t_code CODE_NONE  = 3'd0;
    localparam t_code CODE_LPAR  = 3'd1;
    localparam t_code CODE_PLUS  = 3'd2;
    localparam t_code CODE_MINUS = 3'd3;
    localparam t_code CODE_MUL   = 3'd4;
    localparam t_code CODE_DIV   = 3'd5;
    localparam t_code CODE_CARET = 3'd6;
    localparam t_code CODE_TILDE = 3'd7;

    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_RPAR     = 2'd2,
        ERR_LPAR     = 2'd3
    } t_err;

    typedef enum logic [1:0] {
        K_OPND,
        K_LPAR,
        K_RPAR,
        K_OPER
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_OP,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // stack shift control handed to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_stk_ctl;

    function automatic t_kind char_kind(input logic [7:0] ch);
        case (ch)
            CH_LPAR:  char_kind = K_LPAR;
            CH_RPAR:  char_kind = K_RPAR;
            CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_CARET, CH_TILDE:
                      char_kind = K_OPER;
            default:  char_kind = K_OPND;
        endcase
    endfunction

    function automatic t_code char_code(input logic [7:0] ch);
        case (ch)
            CH_LPAR:  char_code = CODE_LPAR;
            CH_PLUS:  char_code = CODE_PLUS;
            CH_MINUS: char_code = CODE_MINUS;
            CH_MUL:   char_code = CODE_MUL;
            CH_DIV:   char_code = CODE_DIV;
            CH_CARET: char_code = CODE_CARET;
            CH_TILDE: char_code = CODE_TILDE;
            default:  char_code = CODE_NONE;
        endcase
    endfunction

    function automatic logic [7:0] code_char(input t_code code);
        case (code)
            CODE_LPAR:  code_char = CH_LPAR;
            CODE_PLUS:  code_char = CH_PLUS;
            CODE_MINUS: code_char = CH_MINUS;
            CODE_MUL:   code_char = CH_MUL;
            CODE_DIV:   code_char = CH_DIV;
            CODE_CARET: code_char = CH_CARET;
            CODE_TILDE: code_char = CH_TILDE;
            default:    code_char = 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] code_prec(input t_code code);
        case (code)
            CODE_PLUS, CODE_MINUS: code_prec = 3'd1;
            CODE_MUL, CODE_DIV:    code_prec = 3'd2;
            CODE_CARET:            code_prec = 3'd3;
            CODE_TILDE:            code_prec = 3'd4;
            default:               code_prec = 3'd0;
        endcase
    endfunction

    // true when the stacked operator must leave before the incoming one is pushed
    function automatic logic pops_first(input t_code top, input t_code code);
        logic right;
        right = (code == CODE_CARET) || (code == CODE_TILDE);
        if (right) begin
            pops_first = code_prec(top) > code_prec(code);
        end else begin
            pops_first = code_prec(top) >= code_prec(code);
        end
    endfunction

endpackage

[src/infix_to_postfix_converter.sv]
// top level of the infix to postfix converter: sequencer, result buffering and stack
// path: a result of a character passes through the pending slot and the output register
//   before it shows on m_axis
// sequencing: each character goes through ST_OP, ST_FLUSH when s_axis_tlast is set, and
//   ST_DONE before the next one is taken, and m_axis stalls hold it up;
//   the shifting operator stack moves one entry per cycle unless stalled
// reset: synchronous active-low i_rst_n empties the stack count and all valid flags;
//   stack cell contents are left as they are and need no clearing pass
`timescale 1ns / 1ps

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_char
    input  logic       s_axis_tlast,   // expr_end
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic [1:0] m_axis_tuser,   // [1:0] err_code
    output logic       m_axis_tlast    // run_last
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

    // sequencer state
    i2p_pkg::t_state r_state, n_state;

    // latched input character
    logic [7:0]      r_char;
    i2p_pkg::t_kind  r_kind;
    i2p_pkg::t_code  r_code;
    logic            r_last;

    // stack fill count
    logic [CNT_W-1:0] r_cnt;

    // pending result, held until we know whether another one follows it
    logic            r_pend_vld;
    logic [7:0]      r_pend_char;
    i2p_pkg::t_err   r_pend_err;

    // output register
    logic            r_out_vld;
    logic [7:0]      r_out_char;
    i2p_pkg::t_err   r_out_err;
    logic            r_out_last;

    // action of the current cycle
    logic            w_emit;
    logic [7:0]      w_emit_char;
    i2p_pkg::t_err   w_emit_err;
    logic            w_push;
    logic            w_pop;
    logic            w_op_end;
    logic            w_flush_end;
    logic            w_rel;
    logic            w_go;
    logic            w_out_free;
    logic            w_accept;
    logic            w_empty;
    logic            w_full;
    logic            w_out_load;

    i2p_pkg::t_code    w_top;
    i2p_pkg::t_stk_ctl w_stk_ctl;

    assign w_empty    = (r_cnt == '0);
    assign w_full     = (r_cnt >= CNT_FULL);
    assign w_out_free = !r_out_vld || m_axis_tready;
    assign w_accept   = s_axis_tvalid && s_axis_tready;

    // a result can only be taken when the pending slot can drain into the output register
    assign w_go       = !((w_emit || w_rel) && r_pend_vld && !w_out_free);
    assign w_out_load = w_go && r_pend_vld && (w_emit || w_rel);

    // actions per state
    always_comb begin
        w_emit      = 1'b0;
        w_emit_char = 8'h00;
        w_emit_err  = i2p_pkg::ERR_OK;
        w_push      = 1'b0;
        w_pop       = 1'b0;
        w_op_end    = 1'b0;
        w_flush_end = 1'b0;
        w_rel       = 1'b0;
        case (r_state)
            i2p_pkg::ST_OP: begin
                case (r_kind)
                    i2p_pkg::K_OPND: begin
                        w_emit      = 1'b1;
                        w_emit_char = r_char;
                        w_op_end    = 1'b1;
                    end
                    i2p_pkg::K_LPAR: begin
                        // a push onto a full stack turns into an overflow result
                        if (w_full) begin
                            w_emit     = 1'b1;
                            w_emit_err = i2p_pkg::ERR_OVERFLOW;
                        end else begin
                            w_push = 1'b1;
                        end
                        w_op_end = 1'b1;
                    end
                    i2p_pkg::K_RPAR: begin
                        if (w_empty) begin
                            // no matching paren left on the stack
                            w_emit     = 1'b1;
                            w_emit_err = i2p_pkg::ERR_RPAR;
                            w_op_end   = 1'b1;
                        end else begin
                            w_pop = 1'b1;
                            if (w_top == i2p_pkg::CODE_LPAR) begin
                                w_op_end = 1'b1;
                            end else begin
                                w_emit      = 1'b1;
                                w_emit_char = i2p_pkg::code_char(w_top);
                            end
                        end
                    end
                    i2p_pkg::K_OPER: begin
                        if (!w_empty && i2p_pkg::pops_first(w_top, r_code)) begin
                            w_emit      = 1'b1;
                            w_emit_char = i2p_pkg::code_char(w_top);
                            w_pop       = 1'b1;
                        end else begin
                            if (w_full) begin
                                w_emit     = 1'b1;
                                w_emit_err = i2p_pkg::ERR_OVERFLOW;
                            end else begin
                                w_push = 1'b1;
                            end
                            w_op_end = 1'b1;
                        end
                    end
                    default: begin
                        w_op_end = 1'b1;
                    end
                endcase
            end
            i2p_pkg::ST_FLUSH: begin
                if (w_empty) begin
                    w_flush_end = 1'b1;
                end else begin
                    // every open paren still stacked reports itself
                    w_pop  = 1'b1;
                    w_emit = 1'b1;
                    if (w_top == i2p_pkg::CODE_LPAR) begin
                        w_emit_err = i2p_pkg::ERR_LPAR;
                    end else begin
                        w_emit_char = i2p_pkg::code_char(w_top);
                    end
                end
            end
            i2p_pkg::ST_DONE: begin
                w_rel = r_pend_vld;
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            i2p_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = i2p_pkg::ST_OP;
                end
            end
            i2p_pkg::ST_OP: begin
                if (w_go && w_op_end) begin
                    n_state = r_last ? i2p_pkg::ST_FLUSH : i2p_pkg::ST_DONE;
                end
            end
            i2p_pkg::ST_FLUSH: begin
                if (w_flush_end) begin
                    n_state = i2p_pkg::ST_DONE;
                end
            end
            i2p_pkg::ST_DONE: begin
                if (w_go) begin
                    n_state = i2p_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = i2p_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_axis_tready = (r_state == i2p_pkg::ST_IDLE);

    assign w_stk_ctl.push = w_go && w_push;
    assign w_stk_ctl.pop  = w_go && w_pop;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= i2p_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_stk_ctl.push) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_stk_ctl.pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (w_go && w_emit) begin
                r_pend_vld <= 1'b1;
            end else if (w_go && w_rel) begin
                r_pend_vld <= 1'b0;
            end
            if (w_out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_char <= s_axis_tdata;
            r_kind <= i2p_pkg::char_kind(s_axis_tdata);
            r_code <= i2p_pkg::char_code(s_axis_tdata);
            r_last <= s_axis_tlast;
        end
        if (w_go && w_emit) begin
            r_pend_char <= w_emit_char;
            r_pend_err  <= w_emit_err;
        end
        if (w_out_load) begin
            r_out_char <= r_pend_char;
            r_out_err  <= r_pend_err;
            // the pending result closes the run only when it drains at the end
            r_out_last <= w_rel;
        end
    end

    i2p_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk (i_clk),
        .i_ctl (w_stk_ctl),
        .i_new (r_code),
        .o_top (w_top)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = r_out_err;
    assign m_axis_tlast  = r_out_last;

endmodule

[src/i2p_cell.sv]
// one operator stack cell: takes its upper neighbor on push, its lower neighbor on pop
`timescale 1ns / 1ps

module i2p_cell (
    input  logic              i_clk,
    input  i2p_pkg::t_stk_ctl i_ctl,
    input  i2p_pkg::t_code    i_up,
    input  i2p_pkg::t_code    i_dn,
    output i2p_pkg::t_code    o_code
);

    i2p_pkg::t_code r_code;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_code <= i_up;
        end else if (i_ctl.pop) begin
            r_code <= i_dn;
        end
    end

    assign o_code = r_code;

endmodule

[src/i2p_stack.sv]
// operator stack built as a row of shifting cells, top of stack in cell 0
`timescale 1ns / 1ps

module i2p_stack #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  i2p_pkg::t_stk_ctl i_ctl,
    input  i2p_pkg::t_code    i_new,
    output i2p_pkg::t_code    o_top
);

    i2p_pkg::t_code w_code [STACK_DEPTH];

    for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
        i2p_pkg::t_code w_up;
        i2p_pkg::t_code w_dn;

        if (k == 0) begin : g_first
            assign w_up = i_new;
        end else begin : g_mid_up
            assign w_up = w_code[k-1];
        end

        // bottom cell refills with its own value, only entries below the count are read
        if (k == STACK_DEPTH - 1) begin : g_last
            assign w_dn = w_code[k];
        end else begin : g_mid_dn
            assign w_dn = w_code[k+1];
        end

        i2p_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_up   (w_up),
            .i_dn   (w_dn),
            .o_code (w_code[k])
        );
    end

    assign o_top = w_code[0];

endmodule

[src/i2p_checker.sv]
// port-level checker of the infix to postfix converter and its bind
`timescale 1ns / 1ps

module i2p_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // a stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // the converter is not ready in the cycle after it takes a character
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // error results carry no character
    a_err_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != i2p_pkg::ERR_OK) |-> (m_axis_tdata == 8'h00))
        else $error("error result with a character");

    // parentheses never appear in postfix output
    a_no_paren: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata != i2p_pkg::CH_LPAR)
            && (m_axis_tdata != i2p_pkg::CH_RPAR))
        else $error("parenthesis emitted");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[sim/testbench.sv]
// self-checking testbench of the infix to postfix converter with a postfix token scoreboard
`timescale 1ns / 1ps

// one postfix token as it leaves the block
typedef struct packed {
    logic [7:0]    ch;
    i2p_pkg::t_err err;
    logic          last;
} t_rpn_tok;

// keeps its own operator stack and the queue of postfix tokens still due
class rpn_scoreboard;
    i2p_pkg::t_code opstk [i2p_pkg::STACK_DEPTH_DEF];
    int unsigned    level;
    t_rpn_tok       due_tokens [$];
    int unsigned    fails;
    int unsigned    tokens_checked;
    int unsigned    n_overflow;
    int unsigned    n_rpar;
    int unsigned    n_lpar;

    function new();
        level          = 0;
        fails          = 0;
        tokens_checked = 0;
        n_overflow     = 0;
        n_rpar         = 0;
        n_lpar         = 0;
    endfunction

    function logic [7:0] op_char(i2p_pkg::t_code c);
        case (c)
            i2p_pkg::CODE_PLUS:  return i2p_pkg::CH_PLUS;
            i2p_pkg::CODE_MINUS: return i2p_pkg::CH_MINUS;
            i2p_pkg::CODE_MUL:   return i2p_pkg::CH_MUL;
            i2p_pkg::CODE_DIV:   return i2p_pkg::CH_DIV;
            i2p_pkg::CODE_CARET: return i2p_pkg::CH_CARET;
            i2p_pkg::CODE_TILDE: return i2p_pkg::CH_TILDE;
            default:             return i2p_pkg::CH_LPAR;
        endcase
    endfunction

    function int unsigned rank(i2p_pkg::t_code c);
        case (c)
            i2p_pkg::CODE_PLUS, i2p_pkg::CODE_MINUS: return 1;
            i2p_pkg::CODE_MUL, i2p_pkg::CODE_DIV:    return 2;
            i2p_pkg::CODE_CARET:                     return 3;
            i2p_pkg::CODE_TILDE:                     return 4;
            default:                                 return 0;
        endcase
    endfunction

    function void expect_tok(logic [7:0] ch, i2p_pkg::t_err err);
        t_rpn_tok tok;
        tok.ch   = ch;
        tok.err  = err;
        tok.last = 1'b0;
        due_tokens.push_back(tok);
    endfunction

    // works out the tokens that one accepted character releases
    function void take_char(logic [7:0] ch, logic last);
        i2p_pkg::t_code code;
        i2p_pkg::t_code top;
        bit             closing;
        bit             found;
        bit             right;
        int unsigned    mark;
        mark    = due_tokens.size();
        closing = 1'b0;
        code    = i2p_pkg::CODE_NONE;
        case (ch)
            i2p_pkg::CH_LPAR:  code = i2p_pkg::CODE_LPAR;
            i2p_pkg::CH_PLUS:  code = i2p_pkg::CODE_PLUS;
            i2p_pkg::CH_MINUS: code = i2p_pkg::CODE_MINUS;
            i2p_pkg::CH_MUL:   code = i2p_pkg::CODE_MUL;
            i2p_pkg::CH_DIV:   code = i2p_pkg::CODE_DIV;
            i2p_pkg::CH_CARET: code = i2p_pkg::CODE_CARET;
            i2p_pkg::CH_TILDE: code = i2p_pkg::CODE_TILDE;
            i2p_pkg::CH_RPAR:  closing = 1'b1;
            default:           ;
        endcase
        if (closing) begin
            found = 1'b0;
            while (level > 0 && !found) begin
                level--;
                top = opstk[level];
                if (top == i2p_pkg::CODE_LPAR) begin
                    found = 1'b1;
                end else begin
                    expect_tok(op_char(top), i2p_pkg::ERR_OK);
                end
            end
            if (!found) begin
                expect_tok(8'h00, i2p_pkg::ERR_RPAR);
            end
        end else if (code == i2p_pkg::CODE_NONE) begin
            expect_tok(ch, i2p_pkg::ERR_OK);
        end else begin
            // ^ and ~ bind to the right and only yield to strictly stronger operators
            right = (code == i2p_pkg::CODE_CARET) || (code == i2p_pkg::CODE_TILDE);
            if (code != i2p_pkg::CODE_LPAR) begin
                while (level > 0 && (right ? rank(opstk[level-1]) > rank(code)
                                           : rank(opstk[level-1]) >= rank(code))) begin
                    expect_tok(op_char(opstk[level-1]), i2p_pkg::ERR_OK);
                    level--;
                end
            end
            if (level >= i2p_pkg::STACK_DEPTH_DEF) begin
                expect_tok(8'h00, i2p_pkg::ERR_OVERFLOW);
            end else begin
                opstk[level] = code;
                level++;
            end
        end
        if (last) begin
            while (level > 0) begin
                level--;
                if (opstk[level] == i2p_pkg::CODE_LPAR) begin
                    expect_tok(8'h00, i2p_pkg::ERR_LPAR);
                end else begin
                    expect_tok(op_char(opstk[level]), i2p_pkg::ERR_OK);
                end
            end
        end
        if (due_tokens.size() > mark) begin
            due_tokens[due_tokens.size()-1].last = 1'b1;
        end
    endfunction

    function void match_token(logic [7:0] ch, logic [1:0] err, logic last);
        t_rpn_tok want;
        if (due_tokens.size() == 0) begin
            fails++;
            $display("%0t: unexpected token, expected none, actual out_char=%02h err=%0d last=%0b",
                     $time, ch, err, last);
            return;
        end
        want = due_tokens.pop_front();
        tokens_checked++;
        if (ch !== want.ch) begin
            fails++;
            $display("%0t: out_char expected %02h actual %02h", $time, want.ch, ch);
        end
        if (err !== want.err) begin
            fails++;
            $display("%0t: err_code expected %0d actual %0d", $time, want.err, err);
        end
        if (last !== want.last) begin
            fails++;
            $display("%0t: run_last expected %0b actual %0b", $time, want.last, last);
        end
        case (want.err)
            i2p_pkg::ERR_OVERFLOW: n_overflow++;
            i2p_pkg::ERR_RPAR:     n_rpar++;
            i2p_pkg::ERR_LPAR:     n_lpar++;
            default:               ;
        endcase
    endfunction
endclass

module testbench;

    localparam int unsigned ITEMS       = 420;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [7:0]  BIN_OPS [5] = '{i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS,
                                            i2p_pkg::CH_MUL, i2p_pkg::CH_DIV,
                                            i2p_pkg::CH_CARET};
    localparam logic [7:0]  SYNTAX  [8] = '{i2p_pkg::CH_LPAR, i2p_pkg::CH_RPAR,
                                            i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS,
                                            i2p_pkg::CH_MUL, i2p_pkg::CH_DIV,
                                            i2p_pkg::CH_CARET, i2p_pkg::CH_TILDE};

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] in_char
    logic       s_axis_tlast;   // expr_end
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_char
    logic [1:0] m_axis_tuser;   // [1:0] err_code
    logic       m_axis_tlast;   // run_last

    rpn_scoreboard sb;
    logic [7:0]    expr_q [$];
    int unsigned   chars_sent = 0;
    int unsigned   cycle_cnt  = 0;
    bit            gaps_on    = 1'b1;

    infix_to_postfix_converter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // offers one character, with random gaps ahead of it, and waits for the transfer
    task automatic send_char(input logic [7:0] ch, input logic last);
        gaps_on = (chars_sent < 180) || (chars_sent >= 280);
        while (gaps_on && $urandom_range(0, 99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        chars_sent++;
    endtask

    task automatic send_line();
        foreach (expr_q[i]) begin
            send_char(expr_q[i], i == expr_q.size() - 1);
        end
    endtask

    function automatic logic [7:0] any_operand();
        logic [7:0] c;
        if ($urandom_range(0, 7) == 0) begin
            return $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c inside {i2p_pkg::CH_LPAR, i2p_pkg::CH_RPAR, i2p_pkg::CH_PLUS,
                             i2p_pkg::CH_MINUS, i2p_pkg::CH_MUL, i2p_pkg::CH_DIV,
                             i2p_pkg::CH_CARET, i2p_pkg::CH_TILDE});
        return c;
    endfunction

    // well-formed infix text with random operands, operators, prefixes and nesting
    function automatic void add_expr(int unsigned lvl);
        int unsigned terms;
        terms = $urandom_range(1, 4);
        for (int unsigned i = 0; i < terms; i++) begin
            if (i != 0) begin
                expr_q.push_back(BIN_OPS[$urandom_range(0, 4)]);
            end
            while ($urandom_range(0, 3) == 0) begin
                expr_q.push_back(i2p_pkg::CH_TILDE);
            end
            if (lvl < 3 && $urandom_range(0, 3) == 0) begin
                expr_q.push_back(i2p_pkg::CH_LPAR);
                add_expr(lvl + 1);
                expr_q.push_back(i2p_pkg::CH_RPAR);
            end else begin
                expr_q.push_back(any_operand());
            end
        end
    endfunction

    // both stream sides observed at the edge, before any of this edge's updates
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.take_char(s_axis_tdata, s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.match_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    // result side: random backpressure plus one long hold-off so the block fills up
    initial begin
        int unsigned hold_cnt;
        bit          held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!held && chars_sent >= 120) begin
                held     = 1'b1;
                hold_cnt = 0;
                m_axis_tready <= 1'b0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold_cnt++;
                end
            end else begin
                m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 16);
                @(posedge i_clk);
            end
        end
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("** infix_to_postfix_converter: FAILED **");
        $finish;
    end

    initial begin
        // {expr_end, in_char}: every operator, both associativities, operand extremes,
        // a stray ')' over a stacked operator, an open '(' at flush, a lone operator
        logic [8:0]  opening [22];
        int unsigned pick;
        int unsigned n_lines;
        int unsigned n;
        opening = '{{1'b0, i2p_pkg::CH_TILDE}, {1'b0, i2p_pkg::CH_TILDE}, {1'b0, 8'h00},
                    {1'b0, i2p_pkg::CH_CARET}, {1'b0, 8'hFF}, {1'b0, i2p_pkg::CH_CARET},
                    {1'b0, 8'h62}, {1'b0, i2p_pkg::CH_MUL}, {1'b0, i2p_pkg::CH_LPAR},
                    {1'b0, 8'h63}, {1'b0, i2p_pkg::CH_MINUS}, {1'b0, 8'h64},
                    {1'b0, i2p_pkg::CH_RPAR}, {1'b0, i2p_pkg::CH_DIV}, {1'b0, 8'h65},
                    {1'b0, i2p_pkg::CH_PLUS}, {1'b1, 8'h66}, {1'b0, 8'h67},
                    {1'b0, i2p_pkg::CH_PLUS}, {1'b0, i2p_pkg::CH_RPAR},
                    {1'b1, i2p_pkg::CH_LPAR}, {1'b1, i2p_pkg::CH_MINUS}};
        n_lines = 0;
        sb = new();
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) begin
            send_char(opening[i][7:0], opening[i][8]);
        end

        while (chars_sent < ITEMS) begin
            // the first random run is always a deep nest that can overflow the stack early
            pick = (n_lines == 0) ? 99 : $urandom_range(0, 99);
            expr_q.delete();
            if (pick < 75) begin
                add_expr(0);
            end else if (pick < 85) begin
                // stray parenthesis somewhere in an otherwise clean expression
                add_expr(0);
                expr_q.insert($urandom_range(0, expr_q.size()),
                              $urandom_range(0, 1) ? i2p_pkg::CH_LPAR : i2p_pkg::CH_RPAR);
            end else if (pick < 95) begin
                // raw noise, mostly syntax characters, stack carried over between runs
                n = $urandom_range(1, 8);
                repeat (n) begin
                    send_char($urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                        : SYNTAX[$urandom_range(0, 7)],
                              $urandom_range(0, 3) == 0);
                end
            end else begin
                n = $urandom_range(14, 20);
                repeat (n) begin
                    expr_q.push_back($urandom_range(0, 2) != 0 ? i2p_pkg::CH_LPAR
                                                               : i2p_pkg::CH_TILDE);
                end
                expr_q.push_back(any_operand());
                n = $urandom_range(0, 4);
                repeat (n) begin
                    expr_q.push_back(i2p_pkg::CH_RPAR);
                end
            end
            send_line();
            n_lines++;
        end
        s_axis_tvalid <= 1'b0;

        while (sb.due_tokens.size() != 0) begin
            @(posedge i_clk);
        end
        // characters that release nothing may still be in flight
        repeat (40) @(posedge i_clk);

        $display("covered %0d characters (%0d random runs), %0d postfix tokens checked",
                 chars_sent, n_lines, sb.tokens_checked);
        $display("error tokens: %0d overflow, %0d unmatched ')', %0d unmatched '('",
                 sb.n_overflow, sb.n_rpar, sb.n_lpar);
        if (sb.fails == 0 && sb.due_tokens.size() == 0) begin
            $display("** infix_to_postfix_converter: PASSED **");
        end else begin
            $display("** infix_to_postfix_converter: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
src/i2p_pkg.sv
src/i2p_cell.sv
src/i2p_stack.sv
src/infix_to_postfix_converter.sv
src/i2p_checker.sv
sim/testbench.sv
